// File: hw/rtl/zpd_pkg.sv
package zpd_pkg;

  localparam int MAX_LAG_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 15;

  localparam int LAG_CFG_W  = 7;
  localparam int TOL_W      = 16;
  localparam int INFL_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int MARK_W     = 2;
  localparam int MEAN_W     = 23;
  localparam int THR_W      = 31;
  localparam int FRAC_BITS  = 8;

  localparam int LAG_RESET  = 50;
  localparam int TOL_RESET  = 1280;
  localparam int INFL_RESET = 0;
  localparam int MIN_LAG    = 2;

  localparam int ONE_Q16   = 65536;
  localparam int ROUND_Q16 = 32768;
  localparam int Q16_SHIFT = 16;

  localparam int MEAN_MAX = 4194303;
  localparam int MEAN_MIN = -4194304;
  localparam int THR_MAX  = 2147483647;

  typedef enum logic [MARK_W-1:0] {
    MARK_NONE  = 2'd0,
    MARK_ABOVE = 2'd1,
    MARK_BELOW = 2'd2
  } mark_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAG  = 2'd0,
    CFG_TOL  = 2'd1,
    CFG_INFL = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_BLEND,
    S_UPDATE,
    S_STATS,
    S_LQ,
    S_VLOAD,
    S_VAR,
    S_RLOAD,
    S_ROOT,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic blend;
    logic update;
    logic stats;
    logic lq_step;
    logic var_load;
    logic root_load;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fill;
    logic full;
    logic lq_last;
    logic div_done;
    logic sqrt_done;
  } status_t;

endpackage

// File: hw/rtl/zpd_div.sv
module zpd_div #(
  parameter int NW = 59,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [NW-1:0]    quo_r;
  logic [DW:0]      rs;
  logic [DW:0]      diff;
  logic             ge;

  assign rs   = {rem_r, quo_r[NW-1]};
  assign diff = rs - {1'b0, den_r};
  assign ge   = rs >= {1'b0, den_r};
  assign busy = cnt_r != '0;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CNT_W'(NW);
    end else if (busy) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // restoring, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy) begin
      rem_r <= ge ? diff[DW-1:0] : rs[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/zpd_isqrt.sv
module zpd_isqrt #(
  parameter int VW = 59
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [VW-1:0]         v,
  output logic                  busy,
  output logic [(VW+1)/2-1:0]   root
);

  localparam int RW    = (VW + 1) / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    v_r;
  logic [VW-1:0]    root_r;
  logic [VW-1:0]    bit_r;
  logic [VW:0]      trial;
  logic             ge;

  assign trial = {1'b0, root_r} + {1'b0, bit_r};
  assign ge    = {1'b0, v_r} >= trial;
  assign busy  = cnt_r != '0;
  assign root  = root_r[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CNT_W'(RW);
    end else if (busy) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // digit by digit, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (load) begin
      v_r    <= v;
      root_r <= '0;
      bit_r  <= VW'(1) << (2 * (RW - 1));
    end else if (busy) begin
      if (ge) begin
        v_r    <= v_r - trial[VW-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// File: hw/rtl/zpd_dp.sv
module zpd_dp #(
  parameter int MAX_LAG     = zpd_pkg::MAX_LAG_DEF,
  parameter int SAMPLE_BITS = zpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [zpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample,
  input  logic                             in_start_req,
  input  zpd_pkg::cmd_t                    cmd,
  output zpd_pkg::status_t                 st,
  output logic [zpd_pkg::MARK_W-1:0]       out_mark,
  output logic signed [zpd_pkg::MEAN_W-1:0] out_mean_q8,
  output logic [zpd_pkg::THR_W-1:0]        out_threshold_q8
);

  localparam int X_W    = SAMPLE_BITS + zpd_pkg::FRAC_BITS;
  localparam int LEN_W  = $clog2(MAX_LAG + 1);
  localparam int PTR_W  = $clog2(MAX_LAG);
  localparam int SUM_W  = X_W + LEN_W;
  localparam int SQ_W   = 2 * X_W + LEN_W - 1;
  localparam int NUM_W  = SQ_W + LEN_W;
  localparam int DEN_W  = 2 * LEN_W;
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int S2_W   = 2 * SUM_W;
  localparam int WIDE_W = (NUM_W > S2_W) ? NUM_W : S2_W;
  localparam int MN_W   = SUM_W + 2;
  localparam int LQC_W  = $clog2(LEN_W);
  localparam int CMP_W  = LEN_W + zpd_pkg::LAG_CFG_W;
  localparam int DIFF_W = ((X_W > zpd_pkg::MEAN_W) ? X_W : zpd_pkg::MEAN_W) + 1;
  localparam int HC_W   = DIFF_W + zpd_pkg::THR_W;
  localparam int P_W    = X_W + 18;
  localparam int ACC_W  = X_W + 19;
  localparam int TP_W   = zpd_pkg::TOL_W + ROOT_W;
  localparam int TC_W   = TP_W + zpd_pkg::THR_W;

  // configuration
  logic [zpd_pkg::LAG_CFG_W-1:0] lag_r;
  logic [zpd_pkg::TOL_W-1:0]     tol_r;
  logic [zpd_pkg::INFL_W-1:0]    infl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r  <= zpd_pkg::LAG_CFG_W'(zpd_pkg::LAG_RESET);
      tol_r  <= zpd_pkg::TOL_W'(zpd_pkg::TOL_RESET);
      infl_r <= zpd_pkg::INFL_W'(zpd_pkg::INFL_RESET);
    end else if (cfg_we) begin
      case (zpd_pkg::cfg_idx_t'(cfg_index))
        zpd_pkg::CFG_LAG:  lag_r  <= cfg_data[zpd_pkg::LAG_CFG_W-1:0];
        zpd_pkg::CFG_TOL:  tol_r  <= cfg_data[zpd_pkg::TOL_W-1:0];
        zpd_pkg::CFG_INFL: infl_r <= cfg_data[zpd_pkg::INFL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMP_W-1:0]              lag_ext;
  logic [LEN_W-1:0]              len;
  logic [zpd_pkg::INFL_W-1:0]    infl_c;
  logic [zpd_pkg::INFL_W-1:0]    one_minus;

  assign lag_ext = CMP_W'(lag_r);
  assign len = (lag_ext < CMP_W'(zpd_pkg::MIN_LAG)) ? LEN_W'(zpd_pkg::MIN_LAG) :
               (lag_ext > CMP_W'(MAX_LAG)) ? LEN_W'(MAX_LAG) : LEN_W'(lag_ext);
  assign infl_c = (infl_r > zpd_pkg::INFL_W'(zpd_pkg::ONE_Q16)) ?
                  zpd_pkg::INFL_W'(zpd_pkg::ONE_Q16) : infl_r;
  assign one_minus = zpd_pkg::INFL_W'(zpd_pkg::ONE_Q16) - infl_c;

  // waveform state
  logic [LEN_W-1:0]                seen_r;
  logic [PTR_W-1:0]                wp_r;
  logic signed [SUM_W-1:0]         sum_r;
  logic [SQ_W-1:0]                 sq_r;
  logic signed [X_W-1:0]           prevf_r;
  logic signed [zpd_pkg::MEAN_W-1:0] prev_mean_r;
  logic [zpd_pkg::THR_W-1:0]       prev_thr_r;

  // per transaction working registers
  logic signed [X_W-1:0]           x_r;
  logic signed [P_W-1:0]           p1_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic [zpd_pkg::MARK_W-1:0]      res_mark_r;
  logic signed [zpd_pkg::MEAN_W-1:0] res_mean_r;
  logic [zpd_pkg::THR_W-1:0]       res_thr_r;
  logic [S2_W-1:0]                 s2_r;
  logic [NUM_W-1:0]                lq_r;
  logic [LQC_W-1:0]                lqc_r;
  logic                            mean_neg_r;
  logic [zpd_pkg::MARK_W-1:0]      out_mark_r;
  logic signed [zpd_pkg::MEAN_W-1:0] out_mean_r;
  logic [zpd_pkg::THR_W-1:0]       out_thr_r;

  // window memory
  logic signed [X_W-1:0] win_mem [MAX_LAG];
  logic signed [X_W-1:0] rdata_r;
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic signed [X_W-1:0] mem_wdata;
  logic [PTR_W-1:0]      wp_fix;

  logic                  fill;
  logic signed [X_W-1:0] f;
  logic [LEN_W-1:0]      wp_plus;
  logic [PTR_W-1:0]      wp_inc;

  assign fill    = seen_r < len;
  assign wp_fix  = (LEN_W'(wp_r) >= len) ? '0 : wp_r;
  assign wp_plus = LEN_W'(wp_r) + LEN_W'(1);
  assign wp_inc  = (wp_plus >= len) ? '0 : wp_plus[PTR_W-1:0];
  assign f = (res_mark_r != zpd_pkg::MARK_NONE) ? acc_r[zpd_pkg::Q16_SHIFT +: X_W] : x_r;

  assign mem_we    = (cmd.setup && fill) || cmd.update;
  assign mem_waddr = cmd.update ? wp_r : seen_r[PTR_W-1:0];
  assign mem_wdata = cmd.update ? f : x_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.setup) begin
      rdata_r <= win_mem[wp_fix];
    end
  end

  // one shared squarer for the running sums
  logic signed [X_W-1:0] sqr_in;
  logic [X_W-1:0]        sqr_abs;
  logic [2*X_W-1:0]      sqr;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SQ_W-1:0]       sq_nxt;

  assign sqr_in  = cmd.blend ? rdata_r : (cmd.update ? f : x_r);
  assign sqr_abs = sqr_in[X_W-1] ? X_W'(-sqr_in) : X_W'(sqr_in);
  assign sqr     = sqr_abs * sqr_abs;
  assign sum_nxt = cmd.blend ? sum_r - SUM_W'(sqr_in) : sum_r + SUM_W'(sqr_in);
  assign sq_nxt  = cmd.blend ? sq_r - SQ_W'(sqr) : sq_r + SQ_W'(sqr);

  // event test against the previous statistics
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        adiff;
  logic                     hit;
  logic [zpd_pkg::MARK_W-1:0] mark_nxt;

  assign diff  = DIFF_W'(x_r) - DIFF_W'(prev_mean_r);
  assign adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign hit   = HC_W'(adiff) > HC_W'(prev_thr_r);
  assign mark_nxt = !hit ? zpd_pkg::MARK_NONE :
                    (x_r > prev_mean_r) ? zpd_pkg::MARK_ABOVE : zpd_pkg::MARK_BELOW;

  logic signed [P_W-1:0] p1_nxt;
  logic signed [P_W-1:0] p2;
  assign p1_nxt = x_r * $signed({1'b0, infl_c});
  assign p2     = prevf_r * $signed({1'b0, one_minus});

  // statistics
  logic [SUM_W-1:0]  sum_abs;
  logic [WIDE_W-1:0] lq_w;
  logic [WIDE_W-1:0] s2_w;
  logic [NUM_W-1:0]  var_num;
  logic [DEN_W-1:0]  var_den;
  logic [MN_W-1:0]   mn;
  logic [MN_W-1:0]   mn_mag;
  logic [DEN_W-1:0]  mean_den;
  logic              div_load;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quo;
  logic              sq_busy;
  logic [ROOT_W-1:0] root;

  assign sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign lq_w     = WIDE_W'(lq_r);
  assign s2_w     = WIDE_W'(s2_r);
  assign var_num  = (lq_w > s2_w) ? NUM_W'(lq_w - s2_w) : '0;
  assign var_den  = DEN_W'(len) * DEN_W'(len - LEN_W'(1));
  assign mean_den = DEN_W'(len) << 1;
  // floor((2*sum + len) / (2*len)) on the magnitude, rounded towards -inf
  assign mn       = (MN_W'(sum_r) << 1) + MN_W'(len);
  assign mn_mag   = mn[MN_W-1] ? (MN_W'(0) - mn) + MN_W'(mean_den) - MN_W'(1) : mn;

  assign div_load = cmd.var_load || cmd.root_load;
  assign div_num  = cmd.root_load ? NUM_W'(mn_mag) : var_num;
  assign div_den  = cmd.root_load ? mean_den : var_den;

  zpd_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_load),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  zpd_isqrt #(.VW(NUM_W)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.root_load),
    .v     (div_quo),
    .busy  (sq_busy),
    .root  (root)
  );

  logic signed [NUM_W:0]              m_full;
  logic signed [zpd_pkg::MEAN_W-1:0] m_sat;
  logic [TP_W-1:0]                   tp;
  logic [TC_W-1:0]                   tsh;
  logic [zpd_pkg::THR_W-1:0]         t_sat;

  assign m_full = mean_neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign m_sat  = (m_full > (NUM_W+1)'(zpd_pkg::MEAN_MAX)) ?
                    zpd_pkg::MEAN_W'(zpd_pkg::MEAN_MAX) :
                  (m_full < (NUM_W+1)'(zpd_pkg::MEAN_MIN)) ?
                    zpd_pkg::MEAN_W'(zpd_pkg::MEAN_MIN) : zpd_pkg::MEAN_W'(m_full);
  assign tp     = TP_W'(tol_r) * TP_W'(root);
  assign tsh    = TC_W'(tp >> zpd_pkg::FRAC_BITS);
  assign t_sat  = (tsh > TC_W'(zpd_pkg::THR_MAX)) ?
                  zpd_pkg::THR_W'(zpd_pkg::THR_MAX) : zpd_pkg::THR_W'(tsh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      prevf_r     <= '0;
      prev_mean_r <= '0;
      prev_thr_r  <= '0;
    end else begin
      if (cmd.load && in_start_req) begin
        seen_r      <= '0;
        wp_r        <= '0;
        sum_r       <= '0;
        sq_r        <= '0;
        prevf_r     <= '0;
        prev_mean_r <= '0;
        prev_thr_r  <= '0;
      end
      if (cmd.setup) begin
        if (fill) begin
          sum_r   <= sum_nxt;
          sq_r    <= sq_nxt;
          seen_r  <= seen_r + LEN_W'(1);
          wp_r    <= '0;
          prevf_r <= x_r;
        end else begin
          wp_r <= wp_fix;
        end
      end
      if (cmd.blend) begin
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
      end
      if (cmd.update) begin
        sum_r   <= sum_nxt;
        sq_r    <= sq_nxt;
        wp_r    <= wp_inc;
        prevf_r <= f;
      end
      if (cmd.finish) begin
        prev_mean_r <= m_sat;
        prev_thr_r  <= t_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= {in_sample, zpd_pkg::FRAC_BITS'(0)};
    end
    if (cmd.setup) begin
      res_mark_r <= fill ? zpd_pkg::MARK_NONE : mark_nxt;
      res_mean_r <= '0;
      res_thr_r  <= '0;
      p1_r       <= p1_nxt;
    end
    if (cmd.blend) begin
      acc_r <= ACC_W'(p1_r) + ACC_W'(p2) + ACC_W'(zpd_pkg::ROUND_Q16);
    end
    if (cmd.stats) begin
      s2_r  <= sum_abs * sum_abs;
      lq_r  <= '0;
      lqc_r <= '0;
    end
    // len * square sum, one multiplier bit per cycle
    if (cmd.lq_step) begin
      if (len[lqc_r]) begin
        lq_r <= lq_r + (NUM_W'(sq_r) << lqc_r);
      end
      lqc_r <= lqc_r + LQC_W'(1);
    end
    if (cmd.root_load) begin
      mean_neg_r <= mn[MN_W-1];
    end
    if (cmd.finish) begin
      res_mean_r <= m_sat;
      res_thr_r  <= t_sat;
    end
    if (cmd.emit) begin
      out_mark_r <= res_mark_r;
      out_mean_r <= res_mean_r;
      out_thr_r  <= res_thr_r;
    end
  end

  assign st.fill      = fill;
  assign st.full      = (seen_r + LEN_W'(1)) == len;
  assign st.lq_last   = lqc_r == LQC_W'(LEN_W - 1);
  assign st.div_done  = !div_busy;
  assign st.sqrt_done = !sq_busy;

  assign out_mark         = out_mark_r;
  assign out_mean_q8      = out_mean_r;
  assign out_threshold_q8 = out_thr_r;

endmodule

// File: hw/rtl/zpd_ctrl.sv
module zpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  zpd_pkg::status_t  st,
  output zpd_pkg::cmd_t     cmd
);

  zpd_pkg::state_t state_r;
  zpd_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zpd_pkg::S_IDLE:   if (in_valid) state_nxt = zpd_pkg::S_SETUP;
      zpd_pkg::S_SETUP: begin
        if (st.fill) begin
          state_nxt = st.full ? zpd_pkg::S_STATS : zpd_pkg::S_OUT;
        end else begin
          state_nxt = zpd_pkg::S_BLEND;
        end
      end
      zpd_pkg::S_BLEND:  state_nxt = zpd_pkg::S_UPDATE;
      zpd_pkg::S_UPDATE: state_nxt = zpd_pkg::S_STATS;
      zpd_pkg::S_STATS:  state_nxt = zpd_pkg::S_LQ;
      zpd_pkg::S_LQ:     if (st.lq_last) state_nxt = zpd_pkg::S_VLOAD;
      zpd_pkg::S_VLOAD:  state_nxt = zpd_pkg::S_VAR;
      zpd_pkg::S_VAR:    if (st.div_done) state_nxt = zpd_pkg::S_RLOAD;
      zpd_pkg::S_RLOAD:  state_nxt = zpd_pkg::S_ROOT;
      zpd_pkg::S_ROOT:   if (st.div_done && st.sqrt_done) state_nxt = zpd_pkg::S_FINISH;
      zpd_pkg::S_FINISH: state_nxt = zpd_pkg::S_OUT;
      zpd_pkg::S_OUT:    if (slot_free) state_nxt = zpd_pkg::S_IDLE;
      default:           state_nxt = zpd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      zpd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      zpd_pkg::S_SETUP:  cmd.setup     = 1'b1;
      zpd_pkg::S_BLEND:  cmd.blend     = 1'b1;
      zpd_pkg::S_UPDATE: cmd.update    = 1'b1;
      zpd_pkg::S_STATS:  cmd.stats     = 1'b1;
      zpd_pkg::S_LQ:     cmd.lq_step   = 1'b1;
      zpd_pkg::S_VLOAD:  cmd.var_load  = 1'b1;
      zpd_pkg::S_RLOAD:  cmd.root_load = 1'b1;
      zpd_pkg::S_FINISH: cmd.finish    = 1'b1;
      zpd_pkg::S_OUT:    cmd.emit      = slot_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zpd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/zscore_peak_detector_unit.sv
// Smoothed z-score peak detector, Q.8 fixed point.
// Input channel in_*: one sample per transaction; in_start_req begins a new
// waveform and clears the window sums before that sample is used.
// Output channel out_*: one result per input transaction, in order: mark,
// window mean and threshold (mean and threshold are 0 while the window fills).
// Config channel cfg_*: cfg_index 0 lag, 1 tolerance, 2 influence; always
// ready, write only while the block is idle.
// One sample is in flight at a time; in_ready is high only when idle.
// A filling sample goes straight to the output; the sample that completes the
// window and every later one also run the statistics, and later samples first
// blend and update the window. The statistics use the shared bit-serial
// divider (variance, then mean), one quotient bit per cycle over NUM_W, the
// variance numerator width, with the square root overlapping the mean
// division.
// A finished result sits in the output register; if the receiver stalls, the
// next sample is still accepted and processed, then held until the register
// frees up. Reset (synchronous) empties the output, restores the register
// defaults and clears the waveform state; window contents need no clearing.
module zscore_peak_detector_unit #(
  parameter int MAX_LAG     = zpd_pkg::MAX_LAG_DEF,
  parameter int SAMPLE_BITS = zpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [zpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [zpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  logic                              in_start_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [zpd_pkg::MARK_W-1:0]        out_mark,
  output logic signed [zpd_pkg::MEAN_W-1:0] out_mean_q8,
  output logic [zpd_pkg::THR_W-1:0]         out_threshold_q8
);

  zpd_pkg::cmd_t    cmd;
  zpd_pkg::status_t st;

  assign cfg_ready = 1'b1;

  zpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  zpd_dp #(.MAX_LAG(MAX_LAG), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample        (in_sample),
    .in_start_req     (in_start_req),
    .cmd              (cmd),
    .st               (st),
    .out_mark         (out_mark),
    .out_mean_q8      (out_mean_q8),
    .out_threshold_q8 (out_threshold_q8)
  );

endmodule

// File: hw/rtl/zpd_checker.sv
module zpd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [zpd_pkg::MARK_W-1:0]        out_mark,
  input logic signed [zpd_pkg::MEAN_W-1:0] out_mean_q8,
  input logic [zpd_pkg::THR_W-1:0]         out_threshold_q8
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mark) &&
    $stable(out_mean_q8) && $stable(out_threshold_q8))
    else $error("result changed while stalled");

  a_mark_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mark == zpd_pkg::MARK_NONE || out_mark == zpd_pkg::MARK_ABOVE ||
                   out_mark == zpd_pkg::MARK_BELOW))
    else $error("illegal mark code");

  // one sample in flight: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind zscore_peak_detector_unit zpd_checker u_zpd_checker (.*);
